FILE: src/dadv_pkg.sv
// dadv_pkg: shared types, register indexes and calendar constants for the
// date add/validate unit. No dependencies; used by every file under src.

package dadv_pkg;

  // configuration port
  localparam int CFG_AW = 1;
  localparam int CFG_DW = 12;
  localparam logic [CFG_AW-1:0] REG_MIN_YEAR = 1'b0;
  localparam logic [CFG_AW-1:0] REG_MAX_YEAR = 1'b1;

  // result codes
  typedef enum logic [2:0] {
    ERR_OK      = 3'd0,
    ERR_YEAR_LO = 3'd1,
    ERR_YEAR_HI = 3'd2,
    ERR_DAY31   = 3'd3,
    ERR_DAY30   = 3'd4,
    ERR_FEB28   = 3'd5,
    ERR_FEB29   = 3'd6,
    ERR_MONTH   = 3'd7
  } err_code_t;

  // one date to be checked; year flags are resolved by the caller
  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [11:0] year;
    logic        yr_lo;
    logic        yr_hi;
  } date_chk_t;

  // years are shifted so every day count stays positive
  localparam int YEAR_BIAS  = 400;
  localparam int DAYS_400Y  = 146097;
  localparam int DAYS_4Y    = 1461;

  // floor(x/d) = (x * ceil(2^S/d)) >> S holds exactly when x < 2^XW, d < 2^DW, S = XW+DW
  localparam int Q100_SH = 20;  // x: 13 bits, d = 100
  localparam logic [13:0] Q100_MUL = 14'(((64'd1 << Q100_SH) + 64'd99) / 64'd100);
  localparam int CENT_SH = 41;  // x: 23 bits, d = 146097
  localparam logic [23:0] CENT_MUL =
    24'(((64'd1 << CENT_SH) + 64'd146096) / 64'd146097);
  localparam int YOC_SH = 29;   // x: 18 bits, d = 1461
  localparam logic [18:0] YOC_MUL = 19'(((64'd1 << YOC_SH) + 64'd1460) / 64'd1461);
  localparam int MON_SH = 19;   // x: 11 bits, d = 153
  localparam logic [11:0] MON_MUL = 12'(((64'd1 << MON_SH) + 64'd152) / 64'd153);

  // first day of a march-based month within the year, (153*mp+2)/5
  function automatic logic [8:0] mp_start(input logic [3:0] mp);
    logic [8:0] s;
    begin
      case (mp)
        4'd0:    s = 9'd0;
        4'd1:    s = 9'd31;
        4'd2:    s = 9'd61;
        4'd3:    s = 9'd92;
        4'd4:    s = 9'd122;
        4'd5:    s = 9'd153;
        4'd6:    s = 9'd184;
        4'd7:    s = 9'd214;
        4'd8:    s = 9'd245;
        4'd9:    s = 9'd275;
        4'd10:   s = 9'd306;
        4'd11:   s = 9'd337;
        default: s = 9'd0;
      endcase
      return s;
    end
  endfunction

endpackage

FILE: src/dadv_date_check.sv
// dadv_date_check: validates one calendar date against year flags, month
// lengths and the gregorian leap rule. Depends on dadv_pkg.

module dadv_date_check (
  input  dadv_pkg::date_chk_t chk,
  output dadv_pkg::err_code_t err
);

  // divisibility by 25 via the modular inverse of 25 mod 2^12
  localparam logic [11:0] DIV25_INV = 12'd3113;
  localparam logic [11:0] DIV25_LIM = 12'(4095 / 25);

  function automatic logic is_leap(input logic [11:0] y);
    logic [11:0] m;
    logic        d25;
    begin
      m   = 12'(y * DIV25_INV);
      d25 = (m <= DIV25_LIM);
      return (y[1:0] == 2'b00) && (!d25 || (y[3:0] == 4'd0));
    end
  endfunction

  always_comb begin
    err = dadv_pkg::ERR_OK;
    if (chk.yr_lo) begin
      err = dadv_pkg::ERR_YEAR_LO;
    end else if (chk.yr_hi) begin
      err = dadv_pkg::ERR_YEAR_HI;
    end else begin
      case (chk.month) inside
        4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: begin
          if (chk.day == 5'd0) err = dadv_pkg::ERR_DAY31;
        end
        4'd4, 4'd6, 4'd9, 4'd11: begin
          if (chk.day == 5'd0 || chk.day > 5'd30) err = dadv_pkg::ERR_DAY30;
        end
        4'd2: begin
          if (is_leap(chk.year)) begin
            if (chk.day == 5'd0 || chk.day > 5'd29) err = dadv_pkg::ERR_FEB29;
          end else begin
            if (chk.day == 5'd0 || chk.day > 5'd28) err = dadv_pkg::ERR_FEB28;
          end
        end
        default: err = dadv_pkg::ERR_MONTH;
      endcase
    end
  end

endmodule

FILE: src/date_add_days_validate_unit.sv
// date_add_days_validate_unit: top level, ten stage pipeline that adds a signed
// day offset to a gregorian date and checks input and result dates.
// Depends on dadv_pkg and dadv_date_check.
//
//  channel | ports                         | payload, lowest bit first
//  --------+-------------------------------+-------------------------------------------
//  input   | in_tvalid in_tready in_tdata  | day[4:0] month[8:5] year[20:9] offset[37:21]
//  result  | out_tvalid out_tready out_tdata| day[4:0] month[8:5] year[20:9] err[23:21]
//          |                               | err_on_result[24]
//  config  | cfg_we cfg_addr cfg_wdata     | 0: min_year, 1: max_year (12 bits each)
//
// one transaction is taken per cycle while in_tready is high; each input transaction passes
// through the chain of nine compute stages and then the output register
// the multiply-by-reciprocal stages (century, year of century, month) set the stage depth
// rst_n is synchronous and active low; it empties the pipe and restores the year limits
// a stalled output holds only the stages that are full: empty stages behind it keep
// taking input transactions until the whole pipe is full

module date_add_days_validate_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [39:0]                  in_tdata,   // day, month, year, offset_days, pad
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [31:0]                  out_tdata,  // res_day, res_month, res_year,
                                                   // err_code, err_on_result, pad
  input  logic                         cfg_we,
  input  logic [dadv_pkg::CFG_AW-1:0]  cfg_addr,
  input  logic [dadv_pkg::CFG_DW-1:0]  cfg_wdata
);

  localparam int NSTG = 10;  // nine compute stages and the output register

  // ---------------------------------------------------------------- config
  logic [11:0] min_year_r;
  logic [11:0] max_year_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_year_r <= 12'd1902;
      max_year_r <= 12'd2037;
    end else if (cfg_we) begin
      case (cfg_addr)
        dadv_pkg::REG_MIN_YEAR: min_year_r <= cfg_wdata;
        dadv_pkg::REG_MAX_YEAR: max_year_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- flow control
  // a stage loads when it is empty or the stage after it moves on
  logic [NSTG-1:0] stg_vld_r;
  logic [NSTG-1:0] stg_vld_nxt;
  logic [NSTG-1:0] stg_adv;

  always_comb begin
    stg_adv[NSTG-1] = !stg_vld_r[NSTG-1] || out_tready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      stg_adv[k] = !stg_vld_r[k] || stg_adv[k+1];
    end
  end

  assign stg_vld_nxt = {stg_vld_r[NSTG-2:0], in_tvalid};
  assign in_tready   = stg_adv[0];
  assign out_tvalid  = stg_vld_r[NSTG-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (stg_adv[k]) stg_vld_r[k] <= stg_vld_nxt[k];
      end
    end
  end

  // ---------------------------------------------------------------- stage 1
  // input date check, march-based year and day of year
  logic [4:0]         in_day;
  logic [3:0]         in_month;
  logic [11:0]        in_year;
  logic signed [16:0] in_off;
  dadv_pkg::date_chk_t chk_in;
  dadv_pkg::err_code_t err_in;
  logic               in_early;   // january or february count to the year before
  logic [3:0]         in_mp;
  logic [12:0]        s1_yp_nxt;
  logic [8:0]         s1_doy_nxt;

  assign in_day   = in_tdata[4:0];
  assign in_month = in_tdata[8:5];
  assign in_year  = in_tdata[20:9];
  assign in_off   = $signed(in_tdata[37:21]);

  always_comb begin
    chk_in.day   = in_day;
    chk_in.month = in_month;
    chk_in.year  = in_year;
    chk_in.yr_lo = (in_year < min_year_r);
    chk_in.yr_hi = (in_year > max_year_r);
  end

  dadv_date_check u_chk_in (
    .chk (chk_in),
    .err (err_in)
  );

  always_comb begin
    in_early   = (in_month <= 4'd2);
    in_mp      = in_early ? (in_month + 4'd9) : (in_month - 4'd3);
    s1_yp_nxt  = 13'(in_year) + 13'(dadv_pkg::YEAR_BIAS) - 13'(in_early);
    s1_doy_nxt = dadv_pkg::mp_start(in_mp) + 9'(in_day) - 9'd1;
  end

  dadv_pkg::err_code_t s1_err_r;
  logic [12:0]         s1_yp_r;
  logic [8:0]          s1_doy_r;
  logic signed [16:0]  s1_off_r;

  always_ff @(posedge clk) begin
    if (stg_adv[0]) begin
      s1_err_r <= err_in;
      s1_yp_r  <= s1_yp_nxt;
      s1_doy_r <= s1_doy_nxt;
      s1_off_r <= in_off;
    end
  end

  // ---------------------------------------------------------------- stage 2
  // centuries of the year and the plain 365-day part of the day number
  logic [25:0] q100_prod;
  logic [5:0]  s2_q100_nxt;
  logic [20:0] s2_part_nxt;

  always_comb begin
    q100_prod   = 26'(s1_yp_r * dadv_pkg::Q100_MUL);
    s2_q100_nxt = q100_prod[25:dadv_pkg::Q100_SH];
    s2_part_nxt = 21'(s1_yp_r) * 21'd365 + 21'(s1_doy_r);
  end

  dadv_pkg::err_code_t s2_err_r;
  logic [10:0]         s2_yp4_r;
  logic [5:0]          s2_q100_r;
  logic [20:0]         s2_part_r;
  logic signed [16:0]  s2_off_r;

  always_ff @(posedge clk) begin
    if (stg_adv[1]) begin
      s2_err_r  <= s1_err_r;
      s2_yp4_r  <= s1_yp_r[12:2];
      s2_q100_r <= s2_q100_nxt;
      s2_part_r <= s2_part_nxt;
      s2_off_r  <= s1_off_r;
    end
  end

  // ---------------------------------------------------------------- stage 3
  // leap day corrections and the offset give the target day number
  logic [22:0] n_sum;
  logic [20:0] s3_n_nxt;

  always_comb begin
    n_sum = 23'(s2_part_r) + 23'(s2_yp4_r) - 23'(s2_q100_r)
          + 23'(s2_q100_r[5:2]) + 23'(s2_off_r);
    s3_n_nxt = n_sum[20:0];
  end

  dadv_pkg::err_code_t s3_err_r;
  logic [20:0]         s3_n_r;

  always_ff @(posedge clk) begin
    if (stg_adv[2]) begin
      s3_err_r <= s2_err_r;
      s3_n_r   <= s3_n_nxt;
    end
  end

  // ---------------------------------------------------------------- stage 4
  // century index c = (4n+3) / 146097
  logic [46:0] cent_prod;
  logic [5:0]  s4_c_nxt;

  always_comb begin
    cent_prod = {s3_n_r, 2'b11} * dadv_pkg::CENT_MUL;
    s4_c_nxt  = cent_prod[46:dadv_pkg::CENT_SH];
  end

  dadv_pkg::err_code_t s4_err_r;
  logic [20:0]         s4_n_r;
  logic [5:0]          s4_c_r;

  always_ff @(posedge clk) begin
    if (stg_adv[3]) begin
      s4_err_r <= s3_err_r;
      s4_n_r   <= s3_n_r;
      s4_c_r   <= s4_c_nxt;
    end
  end

  // ---------------------------------------------------------------- stage 5
  // day within the century
  logic [23:0] cent_days;
  logic [20:0] cent_rem;
  logic [15:0] s5_r_nxt;

  always_comb begin
    cent_days = 24'(s4_c_r) * 24'(dadv_pkg::DAYS_400Y);
    cent_rem  = s4_n_r - 21'(cent_days[23:2]);
    s5_r_nxt  = cent_rem[15:0];
  end

  dadv_pkg::err_code_t s5_err_r;
  logic [5:0]          s5_c_r;
  logic [15:0]         s5_r_r;

  always_ff @(posedge clk) begin
    if (stg_adv[4]) begin
      s5_err_r <= s4_err_r;
      s5_c_r   <= s4_c_r;
      s5_r_r   <= s5_r_nxt;
    end
  end

  // ---------------------------------------------------------------- stage 6
  // year of century = (4r+3) / 1461
  logic [35:0] yoc_prod;
  logic [6:0]  s6_yy_nxt;

  always_comb begin
    yoc_prod  = 36'({s5_r_r, 2'b11} * dadv_pkg::YOC_MUL);
    s6_yy_nxt = yoc_prod[35:dadv_pkg::YOC_SH];
  end

  dadv_pkg::err_code_t s6_err_r;
  logic [5:0]          s6_c_r;
  logic [15:0]         s6_r_r;
  logic [6:0]          s6_yy_r;

  always_ff @(posedge clk) begin
    if (stg_adv[5]) begin
      s6_err_r <= s5_err_r;
      s6_c_r   <= s5_c_r;
      s6_r_r   <= s5_r_r;
      s6_yy_r  <= s6_yy_nxt;
    end
  end

  // ---------------------------------------------------------------- stage 7
  // day of the march-based year and the biased march-based year
  logic [17:0] yoc_days;
  logic [15:0] doy_full;
  logic [8:0]  s7_doy_nxt;
  logic [12:0] s7_ybh_nxt;

  always_comb begin
    yoc_days   = 18'(s6_yy_r) * 18'(dadv_pkg::DAYS_4Y);
    doy_full   = s6_r_r - yoc_days[17:2];
    s7_doy_nxt = doy_full[8:0];
    s7_ybh_nxt = 13'(s6_c_r) * 13'd100 + 13'(s6_yy_r);
  end

  dadv_pkg::err_code_t s7_err_r;
  logic [8:0]          s7_doy_r;
  logic [12:0]         s7_ybh_r;

  always_ff @(posedge clk) begin
    if (stg_adv[6]) begin
      s7_err_r <= s6_err_r;
      s7_doy_r <= s7_doy_nxt;
      s7_ybh_r <= s7_ybh_nxt;
    end
  end

  // ---------------------------------------------------------------- stage 8
  // march-based month = (5*doy+2) / 153
  logic [10:0] mon_x;
  logic [22:0] mon_prod;
  logic [3:0]  s8_mp_nxt;

  always_comb begin
    mon_x     = 11'(s7_doy_r) * 11'd5 + 11'd2;
    mon_prod  = 23'(mon_x) * 23'(dadv_pkg::MON_MUL);
    s8_mp_nxt = mon_prod[22:dadv_pkg::MON_SH];
  end

  dadv_pkg::err_code_t s8_err_r;
  logic [8:0]          s8_doy_r;
  logic [12:0]         s8_ybh_r;
  logic [3:0]          s8_mp_r;

  always_ff @(posedge clk) begin
    if (stg_adv[7]) begin
      s8_err_r <= s7_err_r;
      s8_doy_r <= s7_doy_r;
      s8_ybh_r <= s7_ybh_r;
      s8_mp_r  <= s8_mp_nxt;
    end
  end

  // ---------------------------------------------------------------- stage 9
  // civil day, month and year; year limits checked before clamping
  logic               res_late;   // january or february belong to the next year
  logic [8:0]         res_day9;
  logic [12:0]        res_yb;
  logic signed [13:0] res_year_s;
  logic [4:0]         s9_day_nxt;
  logic [3:0]         s9_month_nxt;
  logic [11:0]        s9_year_nxt;
  logic               s9_lo_nxt;
  logic               s9_hi_nxt;

  always_comb begin
    res_late     = (s8_mp_r >= 4'd10);
    res_day9     = s8_doy_r - dadv_pkg::mp_start(s8_mp_r) + 9'd1;
    s9_day_nxt   = res_day9[4:0];
    s9_month_nxt = res_late ? (s8_mp_r - 4'd9) : (s8_mp_r + 4'd3);
    res_yb       = s8_ybh_r + 13'(res_late);
    res_year_s   = $signed({1'b0, res_yb}) - 14'(dadv_pkg::YEAR_BIAS);
    s9_lo_nxt    = (res_year_s < $signed({2'b00, min_year_r}));
    s9_hi_nxt    = (res_year_s > $signed({2'b00, max_year_r}));
    if (res_year_s[13]) begin
      s9_year_nxt = 12'd0;
    end else if (res_year_s[12]) begin
      s9_year_nxt = 12'hFFF;
    end else begin
      s9_year_nxt = res_year_s[11:0];
    end
  end

  dadv_pkg::err_code_t s9_err_r;
  logic [4:0]          s9_day_r;
  logic [3:0]          s9_month_r;
  logic [11:0]         s9_year_r;
  logic                s9_lo_r;
  logic                s9_hi_r;

  always_ff @(posedge clk) begin
    if (stg_adv[8]) begin
      s9_err_r   <= s8_err_r;
      s9_day_r   <= s9_day_nxt;
      s9_month_r <= s9_month_nxt;
      s9_year_r  <= s9_year_nxt;
      s9_lo_r    <= s9_lo_nxt;
      s9_hi_r    <= s9_hi_nxt;
    end
  end

  // ---------------------------------------------------------------- output register
  // result date check; an input error wins and blanks the date
  dadv_pkg::date_chk_t chk_res;
  dadv_pkg::err_code_t err_res;

  always_comb begin
    chk_res.day   = s9_day_r;
    chk_res.month = s9_month_r;
    chk_res.year  = s9_year_r;
    chk_res.yr_lo = s9_lo_r;
    chk_res.yr_hi = s9_hi_r;
  end

  dadv_date_check u_chk_res (
    .chk (chk_res),
    .err (err_res)
  );

  logic [4:0]          out_day_nxt;
  logic [3:0]          out_month_nxt;
  logic [11:0]         out_year_nxt;
  dadv_pkg::err_code_t out_err_nxt;
  logic                out_onres_nxt;

  always_comb begin
    if (s9_err_r != dadv_pkg::ERR_OK) begin
      out_day_nxt   = 5'd0;
      out_month_nxt = 4'd0;
      out_year_nxt  = 12'd0;
      out_err_nxt   = s9_err_r;
      out_onres_nxt = 1'b0;
    end else begin
      out_day_nxt   = s9_day_r;
      out_month_nxt = s9_month_r;
      out_year_nxt  = s9_year_r;
      out_err_nxt   = err_res;
      out_onres_nxt = (err_res != dadv_pkg::ERR_OK);
    end
  end

  logic [4:0]          out_day_r;
  logic [3:0]          out_month_r;
  logic [11:0]         out_year_r;
  dadv_pkg::err_code_t out_err_r;
  logic                out_onres_r;

  always_ff @(posedge clk) begin
    if (stg_adv[NSTG-1]) begin
      out_day_r   <= out_day_nxt;
      out_month_r <= out_month_nxt;
      out_year_r  <= out_year_nxt;
      out_err_r   <= out_err_nxt;
      out_onres_r <= out_onres_nxt;
    end
  end

  assign out_tdata = {7'd0, out_onres_r, out_err_r, out_year_r, out_month_r, out_day_r};

endmodule

FILE: src/dadv_checker.sv
// dadv_checker: port-level assertions for date_add_days_validate_unit and the
// bind that attaches them. Depends on dadv_pkg and the top level's ports.

module dadv_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_tvalid,
  input logic                         out_tready,
  input logic [31:0]                  out_tdata
);

  logic [4:0] o_day;
  logic [3:0] o_month;
  logic [11:0] o_year;
  logic [2:0] o_err;
  logic       o_onres;

  assign o_day   = out_tdata[4:0];
  assign o_month = out_tdata[8:5];
  assign o_year  = out_tdata[20:9];
  assign o_err   = out_tdata[23:21];
  assign o_onres = out_tdata[24];

  // pipe is empty after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // a result-side error flag needs an error code
  a_onres_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && o_onres |-> o_err != 3'(dadv_pkg::ERR_OK))
    else $error("result error flag without error code");

  // an input error blanks the date
  a_input_err_blank: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !o_onres && o_err != 3'(dadv_pkg::ERR_OK)
      |-> o_day == 5'd0 && o_month == 4'd0 && o_year == 12'd0)
    else $error("input error with nonzero date");

  // a clean result has a nonzero day and a month from 1 to 12
  a_ok_date: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && o_err == 3'(dadv_pkg::ERR_OK)
      |-> o_day != 5'd0 && o_month >= 4'd1 && o_month <= 4'd12)
    else $error("clean result with impossible date");

endmodule

bind date_add_days_validate_unit dadv_checker u_dadv_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
